### hw/rtl/tsched_pkg.sv
// Shared constants and controller/datapath interface types of the task scheduler.
package tsched_pkg;

  localparam int NUM_SLOTS_DEF = 4;
  localparam int SLOT_PORT_W   = 2;
  localparam int TIME_W        = 16;
  localparam int TICK_W        = 8;
  localparam int RND_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd10;

  localparam logic [1:0] MODE_RR      = 2'd0;
  localparam logic [1:0] MODE_FCFS    = 2'd1;
  localparam logic [1:0] MODE_LOTTERY = 2'd2;
  localparam logic [1:0] MODE_RESET   = MODE_RR;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'b1;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic idx_ptr;
    logic idx_clr;
    logic idx_inc;
    logic rr_apply;
    logic fc_serve;
    logic sum_clr;
    logic sum_acc;
    logic div_init;
    logic div_step;
    logic lt_apply;
    logic out_fire;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       cur_ready;
    logic       idx_last;
    logic       sum_zero;
    logic       div_last;
    logic       pick_hit;
  } ctl_sts_t;

endpackage

### hw/rtl/task_scheduler_rr_fcfs_lottery_unit.sv
// Top level of the round robin / FCFS / lottery task scheduler.
// Steps from acceptance to result strobe: load writes the table; an unused mode goes straight
// to the strobe; round robin reads the slot at the pointer, then applies the quantum; FCFS scans
// one slot per cycle for the first ready slot; lottery sums the tickets, reduces the random value
// modulo a nonzero sum in the bit-serial modulo unit, then walks the registered table to the winner.
// One transaction at a time; busy falls as the result strobe rises and the receiver cannot stall.
// Synchronous reset: all slots finished, round robin pointer 0, mode 0, quantum 10.
module task_scheduler_rr_fcfs_lottery_unit #(
  parameter int NUM_SLOTS = tsched_pkg::NUM_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tsched_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsched_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               start,
  output logic                               busy,
  input  logic                               op,
  input  logic [tsched_pkg::SLOT_PORT_W-1:0] task_slot,
  input  logic [tsched_pkg::TIME_W-1:0]      load_time,
  input  logic [tsched_pkg::TICK_W-1:0]      ticket_count,
  input  logic [tsched_pkg::RND_W-1:0]       random_value,
  output logic                               done,
  output logic [tsched_pkg::SLOT_PORT_W-1:0] served_task,
  output logic                               served_valid,
  output logic                               served_finished,
  output logic                               all_finished
);
  import tsched_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  tsched_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tsched_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .task_slot       (task_slot),
    .load_time       (load_time),
    .ticket_count    (ticket_count),
    .random_value    (random_value),
    .done            (done),
    .served_task     (served_task),
    .served_valid    (served_valid),
    .served_finished (served_finished),
    .all_finished    (all_finished)
  );

  property p_fin_needs_valid;
    @(posedge clk) disable iff (rst) (done && served_finished) |-> served_valid;
  endproperty
  a_fin_needs_valid: assert property (p_fin_needs_valid)
    else $error("finished flag without a served task");

  property p_idle_task_zero;
    @(posedge clk) disable iff (rst) (done && !served_valid) |-> (served_task == '0);
  endproperty
  a_idle_task_zero: assert property (p_idle_task_zero)
    else $error("served task nonzero with no task served");

  property p_accept_sets_busy;
    @(posedge clk) disable iff (rst) (start && !busy) |=> busy;
  endproperty
  a_accept_sets_busy: assert property (p_accept_sets_busy)
    else $error("busy not raised after accepting a transaction");

  property p_single_strobe;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_single_strobe: assert property (p_single_strobe)
    else $error("result strobe held for more than one cycle");

endmodule

### hw/rtl/tsched_dp.sv
// Datapath of the task scheduler: task table, walk counter, ticket sums and modulo unit.
module tsched_dp #(
  parameter int NUM_SLOTS = tsched_pkg::NUM_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tsched_pkg::ctl_cmd_t                  cmd,
  output tsched_pkg::ctl_sts_t                  sts,
  input  logic                                  cfg_we,
  input  logic [tsched_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsched_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [tsched_pkg::SLOT_PORT_W-1:0]    task_slot,
  input  logic [tsched_pkg::TIME_W-1:0]         load_time,
  input  logic [tsched_pkg::TICK_W-1:0]         ticket_count,
  input  logic [tsched_pkg::RND_W-1:0]          random_value,
  output logic                                  done,
  output logic [tsched_pkg::SLOT_PORT_W-1:0]    served_task,
  output logic                                  served_valid,
  output logic                                  served_finished,
  output logic                                  all_finished
);
  import tsched_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int TOT_W  = $clog2(NUM_SLOTS * ((1 << TICK_W) - 1) + 1);
  localparam int CNT_W  = $clog2(RND_W);

  logic [1:0]             mode;
  logic [TIME_W-1:0]      quantum;
  logic [NUM_SLOTS-1:0]   status;
  logic [SLOT_W-1:0]      rr_ptr;
  logic [SLOT_W-1:0]      idx;

  logic [TIME_W-1:0]      time_mem [NUM_SLOTS];
  logic [TICK_W-1:0]      tick_mem [NUM_SLOTS];
  logic [TIME_W-1:0]      time_q;
  logic [TICK_W-1:0]      tick_q;

  logic [SLOT_PORT_W-1:0] cap_slot;
  logic [TIME_W-1:0]      cap_time;
  logic [TICK_W-1:0]      cap_tick;
  logic [RND_W-1:0]       cap_rnd;
  logic [RND_W-1:0]       dvd;

  logic [TOT_W-1:0]       sum;
  logic [TOT_W-1:0]       total;
  logic [TOT_W-1:0]       rem;
  logic [CNT_W-1:0]       cnt;

  logic                   srv_valid;
  logic                   srv_fin;
  logic [SLOT_W-1:0]      srv_task;

  logic                   slot_ok;
  logic [SLOT_W-1:0]      load_addr;
  logic                   cur_ready;
  logic [TOT_W-1:0]       tick_ext;
  logic [TOT_W-1:0]       sum_plus;
  logic [TOT_W:0]         trial;
  logic [TIME_W-1:0]      rr_time;
  logic [TIME_W-1:0]      lt_time;
  logic                   time_we;
  logic [SLOT_W-1:0]      time_addr;
  logic [TIME_W-1:0]      time_wdata;

  assign slot_ok   = 32'(cap_slot) < NUM_SLOTS;
  assign load_addr = SLOT_W'(cap_slot);
  assign cur_ready = status[idx];
  assign tick_ext  = TOT_W'(tick_q);
  assign sum_plus  = cur_ready ? sum + tick_ext : sum;
  assign trial     = {rem, dvd[RND_W-1]};
  assign rr_time   = (time_q > quantum) ? time_q - quantum : '0;
  assign lt_time   = (time_q != '0) ? time_q - 1'b1 : '0;

  always_comb begin
    time_we    = 1'b0;
    time_addr  = idx;
    time_wdata = rr_time;
    priority if (cmd.load_wr) begin
      time_we    = slot_ok;
      time_addr  = load_addr;
      time_wdata = cap_time;
    end else if (cmd.rr_apply) begin
      time_we    = cur_ready;
    end else if (cmd.lt_apply) begin
      time_we    = 1'b1;
      time_wdata = lt_time;
    end
  end

  always_comb begin
    sts.mode      = mode;
    sts.cur_ready = cur_ready;
    sts.idx_last  = idx == SLOT_W'(NUM_SLOTS - 1);
    sts.sum_zero  = sum == '0;
    sts.div_last  = cnt == CNT_W'(RND_W - 1);
    sts.pick_hit  = cur_ready && (sum_plus > rem);
  end

  always_ff @(posedge clk) begin
    if (time_we) begin
      time_mem[time_addr] <= time_wdata;
    end
    if (cmd.load_wr && slot_ok) begin
      tick_mem[load_addr] <= cap_tick;
    end
    time_q <= time_mem[idx];
    tick_q <= tick_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_RESET;
      quantum <= QUANTUM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    mode    <= cfg_data[1:0];
        REG_QUANTUM: quantum <= cfg_data[TIME_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_slot <= task_slot;
      cap_time <= load_time;
      cap_tick <= ticket_count;
      cap_rnd  <= random_value;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.idx_ptr) begin
      idx <= rr_ptr;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.sum_clr) begin
      sum <= '0;
    end else if (cmd.sum_acc) begin
      sum <= sum_plus;
    end
    if (cmd.div_init) begin
      total <= sum;
      rem   <= '0;
      cnt   <= '0;
      dvd   <= cap_rnd;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, total}) begin
        rem <= TOT_W'(trial - {1'b0, total});
      end else begin
        rem <= trial[TOT_W-1:0];
      end
      dvd <= dvd << 1;
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      rr_ptr <= '0;
    end else begin
      priority if (cmd.load_wr) begin
        if (slot_ok) begin
          status[load_addr] <= 1'b1;
        end
      end else if (cmd.rr_apply) begin
        if (cur_ready && rr_time == '0) begin
          status[idx] <= 1'b0;
        end
        rr_ptr <= (rr_ptr == SLOT_W'(NUM_SLOTS - 1)) ? '0 : rr_ptr + 1'b1;
      end else if (cmd.fc_serve) begin
        status[idx] <= 1'b0;
      end else if (cmd.lt_apply) begin
        if (lt_time == '0) begin
          status[idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.capture) begin
      srv_valid <= 1'b0;
      srv_fin   <= 1'b0;
      srv_task  <= '0;
    end else if (cmd.rr_apply) begin
      if (cur_ready) begin
        srv_valid <= 1'b1;
        srv_task  <= idx;
        srv_fin   <= rr_time == '0;
      end
    end else if (cmd.fc_serve) begin
      srv_valid <= 1'b1;
      srv_task  <= idx;
      srv_fin   <= 1'b1;
    end else if (cmd.lt_apply) begin
      srv_valid <= 1'b1;
      srv_task  <= idx;
      srv_fin   <= lt_time == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_fire;
    end
    if (cmd.out_fire) begin
      served_task     <= SLOT_PORT_W'(srv_task);
      served_valid    <= srv_valid;
      served_finished <= srv_fin;
      all_finished    <= ~|status;
    end
  end

endmodule

### hw/rtl/tsched_ctrl.sv
// Controller state machine of the task scheduler.
module tsched_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 op,
  input  tsched_pkg::ctl_sts_t sts,
  output tsched_pkg::ctl_cmd_t cmd,
  output logic                 busy
);
  import tsched_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_RR_WAIT,
    S_RR_APPLY,
    S_FC_SCAN,
    S_LT_SUM_WAIT,
    S_LT_SUM_ACC,
    S_LT_DIV_INIT,
    S_LT_DIV,
    S_LT_PICK_WAIT,
    S_LT_PICK_ACC,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (op == OP_LOAD) begin
            state_next = S_LOAD;
          end else begin
            unique case (sts.mode)
              MODE_RR: begin
                cmd.idx_ptr = 1'b1;
                state_next  = S_RR_WAIT;
              end
              MODE_FCFS: begin
                cmd.idx_clr = 1'b1;
                state_next  = S_FC_SCAN;
              end
              MODE_LOTTERY: begin
                cmd.idx_clr = 1'b1;
                cmd.sum_clr = 1'b1;
                state_next  = S_LT_SUM_WAIT;
              end
              default: state_next = S_DONE;
            endcase
          end
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_RR_WAIT: state_next = S_RR_APPLY;
      S_RR_APPLY: begin
        cmd.rr_apply = 1'b1;
        state_next   = S_DONE;
      end
      S_FC_SCAN: begin
        priority if (sts.cur_ready) begin
          cmd.fc_serve = 1'b1;
          state_next   = S_DONE;
        end else if (sts.idx_last) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_LT_SUM_WAIT: state_next = S_LT_SUM_ACC;
      S_LT_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (sts.idx_last) begin
          state_next = S_LT_DIV_INIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_LT_SUM_WAIT;
        end
      end
      S_LT_DIV_INIT: begin
        if (sts.sum_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          cmd.sum_clr  = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_next   = S_LT_DIV;
        end
      end
      S_LT_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_LT_PICK_WAIT;
        end
      end
      S_LT_PICK_WAIT: state_next = S_LT_PICK_ACC;
      S_LT_PICK_ACC: begin
        priority if (sts.pick_hit) begin
          cmd.lt_apply = 1'b1;
          state_next   = S_DONE;
        end else if (sts.idx_last) begin
          state_next = S_DONE;
        end else begin
          cmd.sum_acc = 1'b1;
          cmd.idx_inc = 1'b1;
          state_next  = S_LT_PICK_WAIT;
        end
      end
      S_DONE: begin
        cmd.out_fire = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  property p_done_goes_idle;
    @(posedge clk) disable iff (rst) (state == S_DONE) |=> (state == S_IDLE);
  endproperty
  a_done_goes_idle: assert property (p_done_goes_idle)
    else $error("controller did not return to idle after result");

  property p_one_table_update;
    @(posedge clk) disable iff (rst)
      $countones({cmd.load_wr, cmd.rr_apply, cmd.fc_serve, cmd.lt_apply}) <= 1;
  endproperty
  a_one_table_update: assert property (p_one_table_update)
    else $error("more than one task table update in a cycle");

  property p_capture_only_idle;
    @(posedge clk) disable iff (rst) cmd.capture |-> (state == S_IDLE) && start;
  endproperty
  a_capture_only_idle: assert property (p_capture_only_idle)
    else $error("transaction captured outside idle");

endmodule
